@@ hdl/alarm_level_output_trigger_core_defines.svh @@
// Assertion macros shared by the alarm trigger RTL.
// ALOT_ASSERT expects clk and rst in the scope where it is used; ALOT_ASSERT_ALWAYS expects clk.
`ifndef ALARM_LEVEL_OUTPUT_TRIGGER_CORE_DEFINES_SVH
`define ALARM_LEVEL_OUTPUT_TRIGGER_CORE_DEFINES_SVH
`ifndef SYNTH
`define ALOT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ALOT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ALOT_ASSERT(lbl, prop, msg)
`define ALOT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ hdl/alot_pkg.sv @@
`default_nettype none
package alot_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned CFG_DATA_MIN    = 32;
  localparam int unsigned HYST_W          = 31;
  localparam int unsigned REG_IDX_W       = 3;

  typedef enum logic [1:0] {
    SEV_NONE    = 2'd0,
    SEV_MINOR   = 2'd1,
    SEV_MAJOR   = 2'd2,
    SEV_INVALID = 2'd3
  } sev_t;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_CALC  = 3'd1,
    KIND_UNDEF = 3'd2,
    KIND_HIHI  = 3'd3,
    KIND_LOLO  = 3'd4,
    KIND_HIGH  = 3'd5,
    KIND_LOW   = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    CALC_OK      = 2'd0,
    CALC_ERROR   = 2'd1,
    CALC_UNAVAIL = 2'd2
  } calc_t;

  typedef enum logic [2:0] {
    MODE_EVERY      = 3'd0,
    MODE_ON_CHANGE  = 3'd1,
    MODE_TO_ZERO    = 3'd2,
    MODE_TO_NONZERO = 3'd3,
    MODE_WHEN_ZERO  = 3'd4,
    MODE_WHEN_NONZ  = 3'd5,
    MODE_NEVER      = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    REG_HIHI     = 3'd0,
    REG_HIGH     = 3'd1,
    REG_LOW      = 3'd2,
    REG_LOLO     = 3'd3,
    REG_HYST     = 3'd4,
    REG_SEV      = 3'd5,
    REG_MODE     = 3'd6,
    REG_DEADBAND = 3'd7
  } reg_idx_t;

  // Packed so that hihi lands in bits 1:0 and low in bits 7:6.
  typedef struct packed {
    sev_t low;
    sev_t high;
    sev_t lolo;
    sev_t hihi;
  } level_sev_t;

  typedef struct packed {
    level_sev_t sev;
    mode_t      mode;
  } cfg_ctrl_t;

  typedef struct packed {
    sev_t  sev;
    kind_t kind;
  } alarm_t;

endpackage
`default_nettype wire

@@ hdl/alot_cfg.sv @@
`default_nettype none
module alot_cfg #(
  parameter int unsigned VALUE_WIDTH = alot_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned DATA_WIDTH  = alot_pkg::CFG_DATA_MIN
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [alot_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [DATA_WIDTH-1:0]               cfg_data,
  output logic signed [VALUE_WIDTH-1:0]       hihi_limit,
  output logic signed [VALUE_WIDTH-1:0]       high_limit,
  output logic signed [VALUE_WIDTH-1:0]       low_limit,
  output logic signed [VALUE_WIDTH-1:0]       lolo_limit,
  output logic [alot_pkg::HYST_W-1:0]         hysteresis,
  output logic [alot_pkg::HYST_W-1:0]         change_deadband,
  output alot_pkg::cfg_ctrl_t                 ctrl
);

  logic write_en;

  assign cfg_ready = 1'b1;
  assign write_en  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hihi_limit      <= '0;
      high_limit      <= '0;
      low_limit       <= '0;
      lolo_limit      <= '0;
      hysteresis      <= '0;
      change_deadband <= '0;
      ctrl            <= '0;
    end else if (write_en) begin
      case (alot_pkg::reg_idx_t'(cfg_index))
        alot_pkg::REG_HIHI:     hihi_limit      <= $signed(cfg_data[VALUE_WIDTH-1:0]);
        alot_pkg::REG_HIGH:     high_limit      <= $signed(cfg_data[VALUE_WIDTH-1:0]);
        alot_pkg::REG_LOW:      low_limit       <= $signed(cfg_data[VALUE_WIDTH-1:0]);
        alot_pkg::REG_LOLO:     lolo_limit      <= $signed(cfg_data[VALUE_WIDTH-1:0]);
        alot_pkg::REG_HYST:     hysteresis      <= cfg_data[alot_pkg::HYST_W-1:0];
        alot_pkg::REG_SEV:      ctrl.sev        <= cfg_data[7:0];
        alot_pkg::REG_MODE:     ctrl.mode       <= alot_pkg::mode_t'(cfg_data[2:0]);
        alot_pkg::REG_DEADBAND: change_deadband <= cfg_data[alot_pkg::HYST_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/alot_grade.sv @@
`default_nettype none
module alot_grade #(
  parameter int unsigned VALUE_WIDTH = alot_pkg::VALUE_WIDTH_DEF
) (
  input  logic signed [VALUE_WIDTH-1:0]  value,
  input  logic                           undefined,
  input  logic                           calc_err,
  input  logic signed [VALUE_WIDTH-1:0]  last_alarm_value,
  input  logic signed [VALUE_WIDTH-1:0]  hihi_limit,
  input  logic signed [VALUE_WIDTH-1:0]  high_limit,
  input  logic signed [VALUE_WIDTH-1:0]  low_limit,
  input  logic signed [VALUE_WIDTH-1:0]  lolo_limit,
  input  logic [alot_pkg::HYST_W-1:0]    hysteresis,
  input  alot_pkg::level_sev_t           level_sev,
  output alot_pkg::alarm_t               alarm,
  output logic signed [VALUE_WIDTH-1:0]  last_alarm_next
);

  localparam int unsigned DIFF_W = VALUE_WIDTH + 1;
  localparam int unsigned CMP_W  = (DIFF_W > alot_pkg::HYST_W) ? DIFF_W : alot_pkg::HYST_W;

  logic hihi_hit;
  logic high_hit;
  logic low_hit;
  logic lolo_hit;

  // At or above the limit, or within hysteresis below it while latched there.
  function automatic logic upper_hit(input logic signed [VALUE_WIDTH-1:0] v,
                                     input logic signed [VALUE_WIDTH-1:0] lim,
                                     input logic signed [VALUE_WIDTH-1:0] latched,
                                     input logic [alot_pkg::HYST_W-1:0]   hyst);
    logic signed [DIFF_W-1:0] gap;
    gap = DIFF_W'(lim) - DIFF_W'(v);
    return (v >= lim) ||
           ((latched == lim) && (CMP_W'($unsigned(gap)) <= CMP_W'(hyst)));
  endfunction

  function automatic logic lower_hit(input logic signed [VALUE_WIDTH-1:0] v,
                                     input logic signed [VALUE_WIDTH-1:0] lim,
                                     input logic signed [VALUE_WIDTH-1:0] latched,
                                     input logic [alot_pkg::HYST_W-1:0]   hyst);
    logic signed [DIFF_W-1:0] gap;
    gap = DIFF_W'(v) - DIFF_W'(lim);
    return (lim >= v) ||
           ((latched == lim) && (CMP_W'($unsigned(gap)) <= CMP_W'(hyst)));
  endfunction

  assign hihi_hit = upper_hit(value, hihi_limit, last_alarm_value, hysteresis);
  assign high_hit = upper_hit(value, high_limit, last_alarm_value, hysteresis);
  assign low_hit  = lower_hit(value, low_limit, last_alarm_value, hysteresis);
  assign lolo_hit = lower_hit(value, lolo_limit, last_alarm_value, hysteresis);

  // First enabled level that matches ends the search, raised or not.
  always_comb begin
    alarm.sev       = calc_err ? alot_pkg::SEV_INVALID : alot_pkg::SEV_NONE;
    alarm.kind      = calc_err ? alot_pkg::KIND_CALC : alot_pkg::KIND_NONE;
    last_alarm_next = last_alarm_value;
    if (undefined) begin
      if (alarm.sev != alot_pkg::SEV_INVALID) begin
        alarm.sev  = alot_pkg::SEV_INVALID;
        alarm.kind = alot_pkg::KIND_UNDEF;
      end
    end else if ((level_sev.hihi != alot_pkg::SEV_NONE) && hihi_hit) begin
      if (level_sev.hihi > alarm.sev) begin
        alarm.sev       = level_sev.hihi;
        alarm.kind      = alot_pkg::KIND_HIHI;
        last_alarm_next = hihi_limit;
      end
    end else if ((level_sev.lolo != alot_pkg::SEV_NONE) && lolo_hit) begin
      if (level_sev.lolo > alarm.sev) begin
        alarm.sev       = level_sev.lolo;
        alarm.kind      = alot_pkg::KIND_LOLO;
        last_alarm_next = lolo_limit;
      end
    end else if ((level_sev.high != alot_pkg::SEV_NONE) && high_hit) begin
      if (level_sev.high > alarm.sev) begin
        alarm.sev       = level_sev.high;
        alarm.kind      = alot_pkg::KIND_HIGH;
        last_alarm_next = high_limit;
      end
    end else if ((level_sev.low != alot_pkg::SEV_NONE) && low_hit) begin
      if (level_sev.low > alarm.sev) begin
        alarm.sev       = level_sev.low;
        alarm.kind      = alot_pkg::KIND_LOW;
        last_alarm_next = low_limit;
      end
    end else begin
      last_alarm_next = value;
    end
  end

endmodule
`default_nettype wire

@@ hdl/alot_trigger.sv @@
`default_nettype none
module alot_trigger #(
  parameter int unsigned VALUE_WIDTH = alot_pkg::VALUE_WIDTH_DEF
) (
  input  logic signed [VALUE_WIDTH-1:0]  value,
  input  logic signed [VALUE_WIDTH-1:0]  previous_value,
  input  logic signed [VALUE_WIDTH-1:0]  last_monitored_value,
  input  logic [alot_pkg::HYST_W-1:0]    change_deadband,
  input  alot_pkg::mode_t                mode,
  output logic                           fire,
  output logic                           changed
);

  localparam int unsigned DIFF_W = VALUE_WIDTH + 1;
  localparam int unsigned CMP_W  = (DIFF_W > alot_pkg::HYST_W) ? DIFF_W : alot_pkg::HYST_W;

  logic step_beyond;
  logic prev_zero;
  logic cur_zero;

  // Exact |a - b| > band.
  function automatic logic beyond(input logic signed [VALUE_WIDTH-1:0] a,
                                  input logic signed [VALUE_WIDTH-1:0] b,
                                  input logic [alot_pkg::HYST_W-1:0]   band);
    logic signed [DIFF_W-1:0] d;
    logic [CMP_W-1:0]         mag;
    d   = DIFF_W'(a) - DIFF_W'(b);
    mag = d[DIFF_W-1] ? CMP_W'($unsigned(-d)) : CMP_W'($unsigned(d));
    return mag > CMP_W'(band);
  endfunction

  assign step_beyond = beyond(previous_value, value, change_deadband);
  assign changed     = beyond(last_monitored_value, value, change_deadband);
  assign prev_zero   = (previous_value == '0);
  assign cur_zero    = (value == '0);

  always_comb begin
    case (mode)
      alot_pkg::MODE_EVERY:      fire = 1'b1;
      alot_pkg::MODE_ON_CHANGE:  fire = step_beyond;
      alot_pkg::MODE_TO_ZERO:    fire = !prev_zero && cur_zero;
      alot_pkg::MODE_TO_NONZERO: fire = prev_zero && !cur_zero;
      alot_pkg::MODE_WHEN_ZERO:  fire = cur_zero;
      alot_pkg::MODE_WHEN_NONZ:  fire = !cur_zero;
      default:                   fire = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/alarm_level_output_trigger_core.sv @@
// Channel   Signals                                      Direction
// ------    -------                                      ---------
// in        in_valid, in_stall, new_value, calc_status   request in
// out       out_valid, out_stall, current_value,         result out
//           severity, alarm_kind, fire_output, value_changed
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data    register write in
//
// One request per cycle while in_stall is low; a taken request loads the input
// register, and its result loads the result register when it moves on (advance).
// Grading, output-mode and deadband logic sit between the two registers and
// update the held/previous/alarm/monitor state in the same cycle.
// rst is synchronous: clears both registers' valid bits, config and state;
// the undefined flag comes up set. No clearing pass.
// A stalled result holds; the input register keeps taking a request as long
// as its content can move on, so in_stall only rises behind a stalled result.
`default_nettype none
`include "alarm_level_output_trigger_core_defines.svh"
module alarm_level_output_trigger_core #(
  parameter int unsigned VALUE_WIDTH = alot_pkg::VALUE_WIDTH_DEF,
  localparam int unsigned DATA_WIDTH =
    (VALUE_WIDTH > alot_pkg::CFG_DATA_MIN) ? VALUE_WIDTH : alot_pkg::CFG_DATA_MIN
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [VALUE_WIDTH-1:0]   new_value,
  input  logic [1:0]                      calc_status,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [VALUE_WIDTH-1:0]   current_value,
  output logic [1:0]                      severity,
  output logic [2:0]                      alarm_kind,
  output logic                            fire_output,
  output logic                            value_changed,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [alot_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [DATA_WIDTH-1:0]           cfg_data
);

  logic signed [VALUE_WIDTH-1:0] hihi_limit;
  logic signed [VALUE_WIDTH-1:0] high_limit;
  logic signed [VALUE_WIDTH-1:0] low_limit;
  logic signed [VALUE_WIDTH-1:0] lolo_limit;
  logic [alot_pkg::HYST_W-1:0]   hysteresis;
  logic [alot_pkg::HYST_W-1:0]   change_deadband;
  alot_pkg::cfg_ctrl_t           ctrl;

  // input register
  logic                          in_full;
  logic signed [VALUE_WIDTH-1:0] in_value;
  logic [1:0]                    in_status;

  // event state
  logic signed [VALUE_WIDTH-1:0] held_value;
  logic signed [VALUE_WIDTH-1:0] previous_value;
  logic signed [VALUE_WIDTH-1:0] last_alarm_value;
  logic signed [VALUE_WIDTH-1:0] last_monitored_value;
  logic                          undefined_flag;

  logic signed [VALUE_WIDTH-1:0] held_value_next;
  logic signed [VALUE_WIDTH-1:0] last_alarm_value_next;
  logic                          undefined_flag_next;
  logic                          calc_err;
  alot_pkg::alarm_t              alarm;
  logic                          fire;
  logic                          changed;

  // result register
  alot_pkg::alarm_t              res_alarm;

  logic advance;
  logic in_accept;

  alot_cfg #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_cfg (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .hihi_limit      (hihi_limit),
    .high_limit      (high_limit),
    .low_limit       (low_limit),
    .lolo_limit      (lolo_limit),
    .hysteresis      (hysteresis),
    .change_deadband (change_deadband),
    .ctrl            (ctrl)
  );

  assign advance   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !advance;
  assign in_accept = in_valid && !in_stall;

  assign calc_err            = (in_status == alot_pkg::CALC_ERROR);
  assign held_value_next     = (in_status == alot_pkg::CALC_OK) ? in_value : held_value;
  assign undefined_flag_next = (in_status == alot_pkg::CALC_OK) ? 1'b0 : undefined_flag;

  alot_grade #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_grade (
    .value            (held_value_next),
    .undefined        (undefined_flag_next),
    .calc_err         (calc_err),
    .last_alarm_value (last_alarm_value),
    .hihi_limit       (hihi_limit),
    .high_limit       (high_limit),
    .low_limit        (low_limit),
    .lolo_limit       (lolo_limit),
    .hysteresis       (hysteresis),
    .level_sev        (ctrl.sev),
    .alarm            (alarm),
    .last_alarm_next  (last_alarm_value_next)
  );

  alot_trigger #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_trigger (
    .value                (held_value_next),
    .previous_value       (previous_value),
    .last_monitored_value (last_monitored_value),
    .change_deadband      (change_deadband),
    .mode                 (ctrl.mode),
    .fire                 (fire),
    .changed              (changed)
  );

  // Capture a request whenever the input register is empty or moving on.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_value  <= new_value;
      in_status <= calc_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_value           <= '0;
      previous_value       <= '0;
      last_alarm_value     <= '0;
      last_monitored_value <= '0;
      undefined_flag       <= 1'b1;
    end else if (advance) begin
      held_value       <= held_value_next;
      previous_value   <= held_value_next;
      last_alarm_value <= last_alarm_value_next;
      undefined_flag   <= undefined_flag_next;
      if (changed) begin
        last_monitored_value <= held_value_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      current_value <= held_value_next;
      res_alarm     <= alarm;
      fire_output   <= fire;
      value_changed <= changed;
    end
  end

  assign severity   = res_alarm.sev;
  assign alarm_kind = res_alarm.kind;

  `ALOT_ASSERT(a_kind_matches_sev, out_valid |-> ((alarm_kind == alot_pkg::KIND_NONE) == (severity == alot_pkg::SEV_NONE)), "alarm kind and severity disagree on no-alarm")
  `ALOT_ASSERT(a_calc_err_keeps_undef, advance && calc_err |=> undefined_flag == $past(undefined_flag), "calculation error changed the undefined flag")
  `ALOT_ASSERT(a_good_value_held, advance && (in_status == alot_pkg::CALC_OK) |=> !undefined_flag && (current_value == $past(in_value)), "good request not held")
  `ALOT_ASSERT(a_undef_is_invalid, advance && undefined_flag_next |=> severity == alot_pkg::SEV_INVALID, "undefined value not graded invalid")
  `ALOT_ASSERT_ALWAYS(a_reset_state, rst |=> !out_valid && !in_stall && undefined_flag, "reset left result valid or value defined")

endmodule
`default_nettype wire
